>>> rtl/hyperplane_sign_hash_defines.svh
// assertion macros shared by the hyperplane sign hash rtl
`ifndef HYPERPLANE_SIGN_HASH_DEFINES_SVH
`define HYPERPLANE_SIGN_HASH_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while rst is high
`define HSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet while rst is high
`define HSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hsh_pkg.sv
// shared types and constants of the hyperplane sign hash
package hsh_pkg;

  localparam int ACC_W  = 40;
  localparam int SIG_W  = 32;
  localparam int CNT_W  = 9;
  localparam int HB_W   = 6;
  localparam int PI_W   = 5;
  localparam int DI_W   = 8;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 9;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_STREAM = 1'b1;

  localparam logic [CFG_IW-1:0] REG_HASH_BITS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_DIMS      = 2'd1;

  localparam logic [HB_W-1:0]  HASH_BITS_RST = 6'd32;
  localparam logic [CNT_W-1:0] DIMS_RST      = 9'd256;

  // pipeline control handed to every plane lane
  typedef struct packed {
    logic adv;
    logic s1_valid;
    logic s2_valid;
    logic s2_last;
  } hsh_ctrl_t;

endpackage

>>> rtl/hsh_ram.sv
// generic single-write, single-read ram with registered read data
module hsh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hsh_lane.sv
// one hyperplane: coefficient column ram, multiplier and dot product accumulator
module hsh_lane import hsh_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_DIMS    = 256
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  hsh_ctrl_t                                    ctrl,
  input  logic                                         wr_en,
  input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] wr_addr,
  input  logic signed [SAMPLE_BITS-1:0]                wr_data,
  input  logic                                         rd_en,
  input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] rd_addr,
  input  logic signed [SAMPLE_BITS-1:0]                sample,
  output logic                                         nonneg
);

  localparam int PROD_W = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] coef;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       sum;

  hsh_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_DIMS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (coef)
  );

  // product is sign-extended into the accumulator width, as two's complement
  assign sum    = acc + ACC_W'(prod);
  assign nonneg = ~sum[ACC_W-1];

  always_ff @(posedge clk) begin
    if (ctrl.adv && ctrl.s1_valid) begin
      prod <= sample * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctrl.adv && ctrl.s2_valid) begin
      acc <= ctrl.s2_last ? '0 : sum;
    end
  end

endmodule

>>> rtl/hyperplane_sign_hash.sv
// an accepted element moves through stages s1 and s2, then its signature is registered onto out_valid
// throughput: one item per cycle while in_stall is low, loads and elements alike
// rate is set by the one read port of each plane's coefficient ram, one column a cycle
// the input stalls only while a finished signature waits and the next one is ready
// reset clears accumulators, element count and pipeline; hash_bits 32, dims 256
// coefficient rams are not cleared and must be loaded before use
`include "hyperplane_sign_hash_defines.svh"

module hyperplane_sign_hash import hsh_pkg::*; #(
  parameter int MAX_PLANES  = 32,
  parameter int MAX_DIMS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [PI_W-1:0]               plane_index,
  input  logic [DI_W-1:0]               dim_index,
  input  logic signed [SAMPLE_BITS-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [SIG_W-1:0]              signature,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [CFG_DW-1:0]             cfg_data
);

  localparam int NLANES = (MAX_PLANES < SIG_W) ? MAX_PLANES : SIG_W;
  localparam int DIM_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [HB_W-1:0]  hash_bits;
  logic [CNT_W-1:0] dims;
  logic [CNT_W-1:0] count;

  logic                          s1_valid;
  logic                          s1_last;
  logic signed [SAMPLE_BITS-1:0] s1_val;
  logic                          s2_valid;
  logic                          s2_last;

  logic              adv;
  logic              accept;
  logic              stream;
  logic              load;
  logic              last;
  logic [31:0]       dims_used;
  logic [31:0]       planes_used;
  logic [DIM_AW-1:0] col;
  logic [SIG_W-1:0]  plane_mask;
  logic [SIG_W-1:0]  sig_next;
  logic [NLANES-1:0] nonneg;
  hsh_ctrl_t         ctrl;

  // freeze only when a signature is about to land on a full, stalled output
  assign adv      = !(s2_valid && s2_last && out_valid && out_stall);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign stream   = accept && (action == ACT_STREAM);
  assign load     = accept && (action == ACT_LOAD) && (32'(dim_index) < MAX_DIMS);

  assign cfg_ready = 1'b1;

  always_comb begin
    dims_used = (dims == '0) ? 32'd1 : 32'(dims);
    if (dims_used > MAX_DIMS) begin
      dims_used = MAX_DIMS;
    end
    planes_used = (hash_bits == '0) ? 32'd1 : 32'(hash_bits);
    if (planes_used > NLANES) begin
      planes_used = NLANES;
    end
  end

  assign last = (32'(count) + 32'd1) >= dims_used;
  assign col  = (32'(count) < MAX_DIMS) ? DIM_AW'(count) : DIM_AW'(MAX_DIMS - 1);

  always_comb begin
    for (int k = 0; k < SIG_W; k++) begin
      plane_mask[k] = k < planes_used;
    end
    sig_next = '0;
    for (int k = 0; k < NLANES; k++) begin
      sig_next[k] = nonneg[k] & plane_mask[k];
    end
  end

  assign ctrl = '{adv: adv, s1_valid: s1_valid, s2_valid: s2_valid, s2_last: s2_last};

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    hsh_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_DIMS    (MAX_DIMS)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .wr_en   (load && (32'(plane_index) == k)),
      .wr_addr (DIM_AW'(dim_index)),
      .wr_data (value),
      .rd_en   (stream),
      .rd_addr (col),
      .sample  (s1_val),
      .nonneg  (nonneg[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits <= HASH_BITS_RST;
      dims      <= DIMS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HASH_BITS: hash_bits <= cfg_data[HB_W-1:0];
        REG_DIMS:      dims      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      s1_valid  <= 1'b0;
      s1_last   <= 1'b0;
      s2_valid  <= 1'b0;
      s2_last   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (stream) begin
        count <= last ? '0 : count + 1'b1;
      end
      if (adv) begin
        s1_valid <= stream;
        s1_last  <= stream && last;
        s1_val   <= value;
        s2_valid <= s1_valid;
        s2_last  <= s1_valid && s1_last;
      end
      if (adv && s2_valid && s2_last) begin
        out_valid <= 1'b1;
        signature <= sig_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `HSH_ASSERT_NOW(a_stall_cause, in_stall,
    out_valid && out_stall && s2_valid && s2_last, "stall without a blocked signature")
  `HSH_ASSERT_NEXT(a_sig_capture, adv && s2_valid && s2_last,
    out_valid && signature == $past(sig_next), "finished signature not captured")
  `HSH_ASSERT_NEXT(a_count_clear, stream && last, count == '0,
    "element count not cleared after last element")
  `HSH_ASSERT_NOW(a_sig_upper, out_valid, (signature >> NLANES) == '0,
    "signature bit set beyond implemented planes")

endmodule

>>> tb/hsh_checker.sv
`timescale 1ns / 100ps
// watches the hash channels, predicts each signature and compares it with the block's output
module hsh_checker import hsh_pkg::*; #(
  parameter int MAX_PLANES  = 32,
  parameter int MAX_DIMS    = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          action,
  input  logic [PI_W-1:0]               plane_index,
  input  logic [DI_W-1:0]               dim_index,
  input  logic signed [SAMPLE_BITS-1:0] value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [SIG_W-1:0]              signature,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IW-1:0]             cfg_index,
  input  logic [CFG_DW-1:0]             cfg_data,
  output int                            fail_count,
  output int                            pending
);

  logic signed [SAMPLE_BITS-1:0] coef_mem [MAX_PLANES][MAX_DIMS];
  logic signed [ACC_W-1:0]       dot_acc [MAX_PLANES];
  logic [CNT_W-1:0]              elem_cnt;
  logic [HB_W-1:0]               hash_bits_reg;
  logic [CNT_W-1:0]              dims_reg;
  logic [SIG_W-1:0]              expected_sigs [$];
  logic [SIG_W-1:0]              oldest_sig;
  int                            mismatches = 0;
  int                            pending_cnt = 0;

  assign fail_count = mismatches;
  assign pending    = pending_cnt;

  function automatic int planes_used();
    int lim;
    int h;
    lim = MAX_PLANES < SIG_W ? MAX_PLANES : SIG_W;
    h = (hash_bits_reg == 0) ? 1 : int'(hash_bits_reg);
    return h > lim ? lim : h;
  endfunction

  function automatic int dims_used();
    int d;
    d = (dims_reg == 0) ? 1 : int'(dims_reg);
    return d > MAX_DIMS ? MAX_DIMS : d;
  endfunction

  task automatic report_mismatch(input string what, input logic [SIG_W-1:0] exp_sig,
                                 input logic [SIG_W-1:0] got_sig);
    $display("mismatch at %0t: %s, expected %h, got %h", $time, what, exp_sig, got_sig);
    mismatches++;
  endtask

  // one vector element into every plane's dot product, signature once the vector is complete
  task automatic absorb_element(input logic signed [SAMPLE_BITS-1:0] elem);
    int col;
    int d;
    int n;
    logic [SIG_W-1:0] sig;
    d = dims_used();
    col = (elem_cnt < MAX_DIMS) ? int'(elem_cnt) : MAX_DIMS - 1;
    for (int k = 0; k < MAX_PLANES; k++) begin
      dot_acc[k] = dot_acc[k] + elem * coef_mem[k][col];
    end
    elem_cnt = elem_cnt + 1'b1;
    if (elem_cnt >= d) begin
      n = planes_used();
      sig = '0;
      for (int k = 0; k < n; k++) begin
        if (!dot_acc[k][ACC_W-1]) sig[k] = 1'b1;
      end
      expected_sigs = {expected_sigs, sig};
      for (int k = 0; k < MAX_PLANES; k++) dot_acc[k] = '0;
      elem_cnt = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PLANES; k++) dot_acc[k] = '0;
      elem_cnt = '0;
      hash_bits_reg = HASH_BITS_RST;
      dims_reg = DIMS_RST;
      expected_sigs.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sigs.size() == 0) begin
          report_mismatch("signature with none pending", '0, signature);
        end else begin
          oldest_sig = expected_sigs.pop_front();
          if (signature !== oldest_sig) report_mismatch("signature", oldest_sig, signature);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HASH_BITS: hash_bits_reg = cfg_data[HB_W-1:0];
          REG_DIMS:      dims_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) begin
          if (plane_index < MAX_PLANES && dim_index < MAX_DIMS)
            coef_mem[plane_index][dim_index] = value;
        end else begin
          absorb_element(value);
        end
      end
    end
    pending_cnt = expected_sigs.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// top of the hyperplane sign hash testbench: clock, reset, stimulus and verdict
module testbench;
  import hsh_pkg::*;

  localparam int MAX_PLANES   = 32;
  localparam int MAX_DIMS     = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_PHASES   = 12;
  localparam int LOAD_COLS    = 16;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          action = ACT_LOAD;
  logic [PI_W-1:0]               plane_index = '0;
  logic [DI_W-1:0]               dim_index = '0;
  logic signed [SAMPLE_BITS-1:0] value = '0;
  logic                          out_stall = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [CFG_IW-1:0]             cfg_index = '0;
  logic [CFG_DW-1:0]             cfg_data = '0;
  logic                          in_stall;
  logic                          out_valid;
  logic                          cfg_ready;
  logic [SIG_W-1:0]              signature;

  int fail_count;
  int pending;
  int gap_pct = 20;
  int stall_pct = 20;
  int hold_token = 0;
  int hold_seen = 0;
  int cycles = 0;
  int n_items;

  always #5 clk = ~clk;

  hyperplane_sign_hash #(
    .MAX_PLANES(MAX_PLANES), .MAX_DIMS(MAX_DIMS), .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .plane_index(plane_index), .dim_index(dim_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .signature(signature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hsh_checker #(
    .MAX_PLANES(MAX_PLANES), .MAX_DIMS(MAX_DIMS), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .plane_index(plane_index), .dim_index(dim_index), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .signature(signature),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stall bursts, or one long hold when asked
  always begin
    @(negedge clk);
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return SAMPLE_MIN;
    if (r < 20) return SAMPLE_MAX;
    if (r < 25) return '0;
    if (r < 30) return '1;
    return SAMPLE_BITS'($urandom);
  endfunction

  // vector lengths stay within the loaded columns
  function automatic logic [CFG_DW-1:0] pick_dims();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return CFG_DW'(LOAD_COLS);
    if (r < 40) return CFG_DW'(1);
    if (r < 85) return CFG_DW'($urandom_range(2, 8));
    return CFG_DW'($urandom_range(9, LOAD_COLS));
  endfunction

  function automatic logic [CFG_DW-1:0] pick_hash_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 25) return CFG_DW'(1);
    if (r < 45) return CFG_DW'(32);
    if (r < 55) return CFG_DW'($urandom_range(33, 511));
    return CFG_DW'($urandom_range(2, 31));
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 45;
    endcase
  endfunction

  task automatic pause_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(input logic act, input logic [PI_W-1:0] pl,
                           input logic [DI_W-1:0] di, input logic signed [SAMPLE_BITS-1:0] val);
    @(negedge clk);
    in_valid <= 1'b1;
    action <= act;
    plane_index <= pl;
    dim_index <= di;
    value <= val;
    do @(posedge clk); while (in_stall);
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) pause_input($urandom_range(1, 5));
  endtask

  task automatic send_coef(input int pl, input int di, input logic signed [SAMPLE_BITS-1:0] val);
    send_item(ACT_LOAD, PI_W'(pl), DI_W'(di), val);
  endtask

  // address fields are don't-care for an element, so they carry noise
  task automatic send_element(input logic signed [SAMPLE_BITS-1:0] val);
    send_item(ACT_STREAM, PI_W'($urandom), DI_W'($urandom), val);
  endtask

  task automatic wait_drain();
    pause_input(1);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    wait_drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // every plane over the columns in use, so no element ever meets an unwritten coefficient
    for (int p = 0; p < MAX_PLANES; p++) begin
      for (int d = 0; d < LOAD_COLS; d++) send_coef(p, d, rand_sample());
    end

    // directed: extremes, zero dot product, register corner values
    write_reg(REG_DIMS, CFG_DW'(1));
    send_coef(0, 0, SAMPLE_MIN);
    send_coef(MAX_PLANES - 1, 0, SAMPLE_MAX);
    send_coef(5, 0, '0);
    send_element(SAMPLE_MAX);
    send_element(SAMPLE_MIN);
    send_element('0);
    send_element('1);
    write_reg(REG_HASH_BITS, CFG_DW'(1));
    send_element(SAMPLE_MIN);
    send_element(SAMPLE_MAX);
    write_reg(REG_HASH_BITS, '0);
    send_element(SAMPLE_BITS'(1));
    write_reg(REG_HASH_BITS, CFG_DW'(63));
    send_element(SAMPLE_MAX);
    write_reg(REG_DIMS, '0);
    send_element(SAMPLE_MIN);
    // load in mid-vector only affects later columns
    write_reg(REG_DIMS, CFG_DW'(3));
    send_element(SAMPLE_MAX);
    send_coef(7, 1, SAMPLE_MAX);
    send_coef(7, 2, SAMPLE_MIN);
    send_element(SAMPLE_MIN);
    send_element(SAMPLE_MAX);
    // shrink dims below the running count: next element closes the vector
    write_reg(REG_DIMS, CFG_DW'(4));
    send_element(rand_sample());
    send_element(rand_sample());
    write_reg(REG_DIMS, CFG_DW'(1));
    send_element(rand_sample());
    write_reg(CFG_IW'(2), '1);
    write_reg(CFG_IW'(3), '0);
    send_element(rand_sample());

    // long receiver hold while elements keep coming, then let everything drain
    write_reg(REG_HASH_BITS, CFG_DW'(32));
    hold_token++;
    repeat (40) send_element(rand_sample());
    wait_drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == NUM_PHASES - 1) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = pick_pct();
        stall_pct = pick_pct();
      end
      write_reg(REG_HASH_BITS, pick_hash_bits());
      if (phase == 1 || phase == 5) write_reg(REG_DIMS, CFG_DW'(LOAD_COLS));
      else write_reg(REG_DIMS, pick_dims());
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IW'($urandom_range(2, 3)), CFG_DW'($urandom));
      n_items = (phase == 1 || phase == 5) ? 120 : 60;
      repeat (n_items) begin
        if ($urandom_range(0, 99) < 20)
          send_coef($urandom_range(0, MAX_PLANES - 1), $urandom_range(0, MAX_DIMS - 1),
                    rand_sample());
        else
          send_element(rand_sample());
      end
    end

    wait_drain();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
